// File: rtl/core/mqpb_pkg.sv
package mqpb_pkg;

    localparam int NUM_QUEUES_DEF  = 11;
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int MAX_PAYLOAD_DEF = 32;

    localparam int         CFG_W         = 6;
    localparam logic [5:0] CFG_RESET_VAL = 6'd30;

    typedef enum logic [1:0] {
        OP_ENQ = 2'd0,
        OP_DEQ = 2'd1,
        OP_QRY = 2'd2,
        OP_CLR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_COUNT = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DESC,
        S_HDR,
        S_DQ,
        S_RESP
    } state_t;

    typedef struct packed {
        op_t        operation;
        logic [3:0] queue_sel;
        logic [7:0] src_addr;
        logic [7:0] dst_addr;
        logic [7:0] payload_byte;
        logic       payload_last;
    } item_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] out_src;
        logic [7:0] out_dst;
        logic [7:0] out_byte;
        logic       out_last;
        logic [3:0] packet_count;
    } result_t;

endpackage

// File: rtl/core/mqpb_ram.sv
module mqpb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/mqpb_ctrl.sv
module mqpb_ctrl #(
    parameter int NUM_QUEUES  = mqpb_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = mqpb_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_PAYLOAD = mqpb_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  mqpb_pkg::item_t                     in_item,
    input  logic [$clog2(MAX_PAYLOAD+1)-1:0]    lim,
    output logic                                res_valid,
    input  logic                                res_ready,
    output mqpb_pkg::result_t                   res
);

    localparam int QW     = NUM_QUEUES > 1 ? $clog2(NUM_QUEUES) : 1;
    localparam int PTR_W  = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int OFF_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int SLOTS  = NUM_QUEUES * QUEUE_DEPTH;
    localparam int SLOT_W = SLOTS > 1 ? $clog2(SLOTS) : 1;
    localparam int PDEPTH = SLOTS * MAX_PAYLOAD;
    localparam int PA_W   = PDEPTH > 1 ? $clog2(PDEPTH) : 1;
    localparam int DESC_W = 2 * PTR_W + CNT_W;
    localparam int META_W = 16 + OFF_W;

    mqpb_pkg::state_t state_reg, state_next;
    mqpb_pkg::item_t  item_reg, item_next;
    logic [OFF_W-1:0]      wo_reg, wo_next;
    logic [NUM_QUEUES-1:0] valid_reg, valid_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [OFF_W-1:0]      len_reg, len_next;
    logic [OFF_W-1:0]      idx_reg, idx_next;
    mqpb_pkg::status_t     rsp_status_reg, rsp_status_next;
    logic [CNT_W-1:0]      rsp_count_reg, rsp_count_next;

    logic              desc_we, desc_re;
    logic [QW-1:0]     desc_raddr;
    logic [DESC_W-1:0] desc_wdata, desc_rdata;
    logic              meta_we, meta_re;
    logic [SLOT_W-1:0] meta_waddr, meta_raddr;
    logic [META_W-1:0] meta_wdata, meta_rdata;
    logic              pay_we, pay_re;
    logic [PA_W-1:0]   pay_waddr, pay_raddr;
    logic [7:0]        pay_rdata;

    logic [QW-1:0]    q_idx;
    logic             q_ok, q_live;
    logic [PTR_W-1:0] head, tail;
    logic [CNT_W-1:0] cnt;
    logic             room, store;
    logic [OFF_W-1:0] wo_new, len_new, deq_len;
    logic [SLOT_W-1:0] tail_slot, head_slot;
    logic             deq_last;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_of(input logic [QW-1:0] q,
                                                    input logic [PTR_W-1:0] p);
        return SLOT_W'(q) * SLOT_W'(QUEUE_DEPTH) + SLOT_W'(p);
    endfunction

    function automatic logic [PA_W-1:0] byte_addr(input logic [SLOT_W-1:0] s,
                                                   input logic [OFF_W-1:0] o);
        return PA_W'(s) * PA_W'(MAX_PAYLOAD) + PA_W'(o);
    endfunction

    mqpb_ram #(.WIDTH(DESC_W), .DEPTH(NUM_QUEUES)) u_desc (
        .clk   (clk),
        .we    (desc_we),
        .waddr (q_idx),
        .wdata (desc_wdata),
        .re    (desc_re),
        .raddr (desc_raddr),
        .rdata (desc_rdata)
    );

    mqpb_ram #(.WIDTH(META_W), .DEPTH(SLOTS)) u_meta (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .re    (meta_re),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    mqpb_ram #(.WIDTH(8), .DEPTH(PDEPTH)) u_payload (
        .clk   (clk),
        .we    (pay_we),
        .waddr (pay_waddr),
        .wdata (item_reg.payload_byte),
        .re    (pay_re),
        .raddr (pay_raddr),
        .rdata (pay_rdata)
    );

    // queue table lookup, an entry never written since reset or clear reads as empty
    assign q_idx  = QW'(item_reg.queue_sel);
    assign q_ok   = 7'(item_reg.queue_sel) < 7'(NUM_QUEUES);
    assign q_live = q_ok && valid_reg[q_idx];
    assign head   = q_live ? desc_rdata[DESC_W-1 -: PTR_W] : '0;
    assign tail   = q_live ? desc_rdata[CNT_W +: PTR_W] : '0;
    assign cnt    = q_live ? desc_rdata[CNT_W-1:0] : '0;

    assign room      = q_ok && (cnt < CNT_W'(QUEUE_DEPTH));
    assign store     = room && (wo_reg < lim);
    assign wo_new    = (wo_reg < lim) ? wo_reg + OFF_W'(1) : wo_reg;
    assign len_new   = (wo_new < lim) ? wo_new : lim;
    assign tail_slot = slot_of(q_idx, tail);
    assign head_slot = slot_of(q_idx, head);

    assign deq_len  = (meta_rdata[OFF_W-1:0] == '0) ? OFF_W'(1) : meta_rdata[OFF_W-1:0];
    assign deq_last = (idx_reg + OFF_W'(1)) == deq_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mqpb_pkg::S_IDLE;
            wo_reg    <= '0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wo_reg    <= wo_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        slot_reg       <= slot_next;
        len_reg        <= len_next;
        idx_reg        <= idx_next;
        rsp_status_reg <= rsp_status_next;
        rsp_count_reg  <= rsp_count_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        wo_next         = wo_reg;
        valid_next      = valid_reg;
        slot_next       = slot_reg;
        len_next        = len_reg;
        idx_next        = idx_reg;
        rsp_status_next = rsp_status_reg;
        rsp_count_next  = rsp_count_reg;

        in_ready   = 1'b0;
        desc_re    = 1'b0;
        desc_raddr = QW'(in_item.queue_sel);
        desc_we    = 1'b0;
        desc_wdata = {head, tail, cnt};
        meta_we    = 1'b0;
        meta_waddr = tail_slot;
        meta_wdata = {item_reg.src_addr, item_reg.dst_addr, len_new};
        meta_re    = 1'b0;
        meta_raddr = tail_slot;
        pay_we     = 1'b0;
        pay_waddr  = byte_addr(tail_slot, wo_reg);
        pay_re     = 1'b0;
        pay_raddr  = byte_addr(head_slot, '0);

        res_valid        = 1'b0;
        res.status       = rsp_status_reg;
        res.out_src      = '0;
        res.out_dst      = '0;
        res.out_byte     = '0;
        res.out_last     = 1'b1;
        res.packet_count = 4'(rsp_count_reg);

        unique case (state_reg)
            mqpb_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next  = in_item;
                    desc_re    = 1'b1;
                    state_next = mqpb_pkg::S_DESC;
                end
            end

            mqpb_pkg::S_DESC:
            begin
                unique case (item_reg.operation)
                    mqpb_pkg::OP_ENQ:
                    begin
                        pay_we  = store;
                        meta_we = store;
                        wo_next = item_reg.payload_last ? '0 : wo_new;
                        if (!item_reg.payload_last)
                        begin
                            state_next = mqpb_pkg::S_IDLE;
                        end
                        else if (!room)
                        begin
                            rsp_status_next = mqpb_pkg::ST_FULL;
                            rsp_count_next  = cnt;
                            state_next      = mqpb_pkg::S_RESP;
                        end
                        else
                        begin
                            desc_we           = 1'b1;
                            desc_wdata        = {head, ptr_inc(tail), cnt + CNT_W'(1)};
                            valid_next[q_idx] = 1'b1;
                            rsp_status_next   = mqpb_pkg::ST_OK;
                            rsp_count_next    = cnt + CNT_W'(1);
                            slot_next         = tail_slot;
                            len_next          = len_new;
                            if (store)
                            begin
                                state_next = mqpb_pkg::S_RESP;
                            end
                            else
                            begin
                                // last byte truncated, keep the stored header
                                meta_re    = 1'b1;
                                state_next = mqpb_pkg::S_HDR;
                            end
                        end
                    end

                    mqpb_pkg::OP_DEQ:
                    begin
                        if (cnt == '0)
                        begin
                            rsp_status_next = mqpb_pkg::ST_EMPTY;
                            rsp_count_next  = '0;
                            state_next      = mqpb_pkg::S_RESP;
                        end
                        else
                        begin
                            meta_re           = 1'b1;
                            meta_raddr        = head_slot;
                            pay_re            = 1'b1;
                            desc_we           = 1'b1;
                            desc_wdata        = {ptr_inc(head), tail, cnt - CNT_W'(1)};
                            valid_next[q_idx] = 1'b1;
                            rsp_count_next    = cnt - CNT_W'(1);
                            slot_next         = head_slot;
                            idx_next          = '0;
                            state_next        = mqpb_pkg::S_DQ;
                        end
                    end

                    mqpb_pkg::OP_QRY:
                    begin
                        rsp_status_next = mqpb_pkg::ST_COUNT;
                        rsp_count_next  = cnt;
                        state_next      = mqpb_pkg::S_RESP;
                    end

                    mqpb_pkg::OP_CLR:
                    begin
                        if (q_ok)
                        begin
                            valid_next[q_idx] = 1'b0;
                        end
                        rsp_status_next = mqpb_pkg::ST_OK;
                        rsp_count_next  = '0;
                        state_next      = mqpb_pkg::S_RESP;
                    end

                    default:
                    begin
                        state_next = mqpb_pkg::S_IDLE;
                    end
                endcase
            end

            mqpb_pkg::S_HDR:
            begin
                meta_we    = 1'b1;
                meta_waddr = slot_reg;
                meta_wdata = {meta_rdata[META_W-1:OFF_W], len_reg};
                state_next = mqpb_pkg::S_RESP;
            end

            mqpb_pkg::S_DQ:
            begin
                res.status   = mqpb_pkg::ST_OK;
                res.out_src  = meta_rdata[META_W-1 -: 8];
                res.out_dst  = meta_rdata[OFF_W +: 8];
                res.out_byte = pay_rdata;
                res.out_last = deq_last;
                if (res_ready)
                begin
                    res_valid = 1'b1;
                    if (deq_last)
                    begin
                        state_next = mqpb_pkg::S_IDLE;
                    end
                    else
                    begin
                        idx_next  = idx_reg + OFF_W'(1);
                        pay_re    = 1'b1;
                        pay_raddr = byte_addr(slot_reg, idx_reg + OFF_W'(1));
                    end
                end
            end

            mqpb_pkg::S_RESP:
            begin
                if (res_ready)
                begin
                    res_valid  = 1'b1;
                    state_next = mqpb_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = mqpb_pkg::S_IDLE;
            end
        endcase
    end

    a_lookup_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == mqpb_pkg::S_DESC)
        else $error("accepted item not followed by queue table lookup");

    a_desc_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(desc_we && desc_re))
        else $error("queue table read and write in the same cycle");

    a_desc_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mqpb_pkg::S_DESC |=> state_reg != mqpb_pkg::S_DESC)
        else $error("lookup state held for more than one cycle");

    a_dq_index: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mqpb_pkg::S_DQ |-> idx_reg < deq_len)
        else $error("dequeue byte index past packet length");

    a_offset_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wo_reg <= OFF_W'(MAX_PAYLOAD))
        else $error("write offset past payload maximum");

endmodule

// File: rtl/core/multi_queue_packet_buffer_top.sv
// enqueue byte: accept, then queue table lookup; a last byte then waits in the result state
// commit result follows the lookup; a truncated last byte passes through a header write state first,
// as the stored header is read back before the length is written
// dequeue: first byte follows the lookup, then one per cycle while the output register is free
// query, clear and empty dequeue: accept, queue table lookup, then result state
// reset: async, clears sequencer, queue table, write offset, output valid; limit to 30
module multi_queue_packet_buffer_top #(
    parameter int NUM_QUEUES  = mqpb_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = mqpb_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_PAYLOAD = mqpb_pkg::MAX_PAYLOAD_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // queue_sel, src_addr, dst_addr, payload_byte
    input  logic [1:0]  s_axis_tuser,  // operation
    input  logic        s_axis_tlast,  // payload_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // out_src, out_dst, out_byte, packet_count
    output logic [1:0]  m_axis_tuser,  // status
    output logic        m_axis_tlast,  // out_last
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data
);

    localparam int OFF_W = $clog2(MAX_PAYLOAD + 1);

    logic [mqpb_pkg::CFG_W-1:0] cfg_reg, cfg_next;
    logic [6:0]                 lim_wide;
    logic [OFF_W-1:0]           lim;

    mqpb_pkg::item_t   in_item;
    mqpb_pkg::result_t res;
    logic              res_valid, res_ready;

    logic              out_valid_reg, out_valid_next;
    mqpb_pkg::result_t out_res_reg, out_res_next;

    assign cfg_next = cfg_wr_en ? cfg_wr_data : cfg_reg;

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            lim_wide = 7'd1;
        end
        else if (7'(cfg_reg) > 7'(MAX_PAYLOAD))
        begin
            lim_wide = 7'(MAX_PAYLOAD);
        end
        else
        begin
            lim_wide = 7'(cfg_reg);
        end
    end

    assign lim = OFF_W'(lim_wide);

    assign in_item.operation    = mqpb_pkg::op_t'(s_axis_tuser);
    assign in_item.queue_sel    = s_axis_tdata[3:0];
    assign in_item.src_addr     = s_axis_tdata[11:4];
    assign in_item.dst_addr     = s_axis_tdata[19:12];
    assign in_item.payload_byte = s_axis_tdata[27:20];
    assign in_item.payload_last = s_axis_tlast;

    mqpb_ctrl #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .lim       (lim),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register, frees when empty or taken this cycle
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= mqpb_pkg::CFG_RESET_VAL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.status;
    assign m_axis_tlast  = out_res_reg.out_last;
    assign m_axis_tdata  = {4'b0000, out_res_reg.packet_count, out_res_reg.out_byte,
                            out_res_reg.out_dst, out_res_reg.out_src};

endmodule
